>>> rtl/spq_pkg.sv
// Shared constants, codes and types for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Sizing
  localparam int DEPTH        = 256;
  localparam int PAYLOAD_BITS = 32;

  localparam int KeyW      = 16;
  localparam int PortPayW  = 32;
  localparam int RankW     = 8;
  localparam int OccW      = 9;
  localparam int PayW      = (PAYLOAD_BITS < PortPayW) ? PAYLOAD_BITS : PortPayW;
  localparam int IdxW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW      = $clog2(DEPTH + 1);
  localparam int RankCmpW  = (CntW > RankW) ? CntW : RankW;

  // Rank read tree: first level ORs groups of cells, second level ORs groups
  localparam int GroupSize = 16;
  localparam int NumGroups = (DEPTH + GroupSize - 1) / GroupSize;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_RANK  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD1,
    ST_RD2
  } spq_state_e;

  // Update strobes broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/spq_cell.sv
// One slot of the sorted chain: holds a key and payload, shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic            clk_i,
  input  wire spq_cell_ctrl_t  ctrl_i,
  input  wire logic            valid_i,
  input  wire logic            hit_i,
  input  wire logic [KeyW-1:0] new_key_i,
  input  wire logic [PayW-1:0] new_pay_i,
  input  wire logic            prev_ge_i,
  input  wire logic [KeyW-1:0] prev_key_i,
  input  wire logic [PayW-1:0] prev_pay_i,
  input  wire logic [KeyW-1:0] next_key_i,
  input  wire logic [PayW-1:0] next_pay_i,
  output logic                 ge_o,
  output logic [KeyW-1:0]      key_o,
  output logic [PayW-1:0]      pay_o,
  output logic [KeyW-1:0]      sel_key_o,
  output logic [PayW-1:0]      sel_pay_o
);

  logic [KeyW-1:0] key_q, key_d;
  logic [PayW-1:0] pay_q, pay_d;

  // Slot keeps its entry when it holds a key not below the new one (ties stay ahead)
  assign ge_o = valid_i && (key_q >= new_key_i);

  // Insert: first slot that loses takes the new word, the rest take from above.
  // Remove: every slot takes from below.
  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (ctrl_i.ins && !ge_o) begin
      if (prev_ge_i) begin
        key_d = new_key_i;
        pay_d = new_pay_i;
      end else begin
        key_d = prev_key_i;
        pay_d = prev_pay_i;
      end
    end else if (ctrl_i.rem) begin
      key_d = next_key_i;
      pay_d = next_pay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o     = key_q;
  assign pay_o     = pay_q;
  // Gated copy for the rank read tree
  assign sel_key_o = hit_i ? key_q : '0;
  assign sel_pay_o = hit_i ? pay_q : '0;

endmodule

`default_nettype wire

>>> rtl/spq_rank_tree.sv
// Two-level registered OR tree that gathers the one selected cell for a rank read.
`timescale 1ns / 1ps
`default_nettype none

module spq_rank_tree
  import spq_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic [KeyW-1:0] sel_key_i [DEPTH],
  input  wire logic [PayW-1:0] sel_pay_i [DEPTH],
  output logic [KeyW-1:0]      key_o,
  output logic [PayW-1:0]      pay_o
);

  localparam int PadDepth = NumGroups * GroupSize;

  logic [KeyW-1:0] pad_key [PadDepth];
  logic [PayW-1:0] pad_pay [PadDepth];
  logic [KeyW-1:0] grp_key_q [NumGroups];
  logic [PayW-1:0] grp_pay_q [NumGroups];
  logic [KeyW-1:0] key_q, key_d;
  logic [PayW-1:0] pay_q, pay_d;

  // Pad the cell row up to a whole number of groups
  for (genvar i = 0; i < PadDepth; i++) begin : g_pad
    if (i < DEPTH) begin : g_real
      assign pad_key[i] = sel_key_i[i];
      assign pad_pay[i] = sel_pay_i[i];
    end else begin : g_zero
      assign pad_key[i] = '0;
      assign pad_pay[i] = '0;
    end
  end

  // First level: one OR per group, registered
  for (genvar g = 0; g < NumGroups; g++) begin : g_grp
    logic [KeyW-1:0] acc_key;
    logic [PayW-1:0] acc_pay;

    always_comb begin
      acc_key = '0;
      acc_pay = '0;
      for (int j = 0; j < GroupSize; j++) begin
        acc_key = acc_key | pad_key[g*GroupSize + j];
        acc_pay = acc_pay | pad_pay[g*GroupSize + j];
      end
    end

    always_ff @(posedge clk_i) begin
      grp_key_q[g] <= acc_key;
      grp_pay_q[g] <= acc_pay;
    end
  end

  // Second level: OR across the groups, registered
  always_comb begin
    key_d = '0;
    pay_d = '0;
    for (int g = 0; g < NumGroups; g++) begin
      key_d = key_d | grp_key_q[g];
      pay_d = pay_d | grp_pay_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: command sequencer, cell chain and result register.
// The queue holds up to DEPTH entries in a chain of cells kept sorted largest key first,
// equal keys in insertion order. One command is worked at a time. For insert and remove the
// command is first accepted and captured; then, once the result register is free, the
// cells compare against the new key and shift with their neighbours while the result register
// loads. A rank read passes through the two registered levels of the OR tree that gathers
// the selected cell before its result loads, again once the result register is free. A new
// command is accepted in the cycle after the previous one has reached the result register,
// even while that result still waits on a stall. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          command_i,
  input  wire logic [KeyW-1:0]     new_key_i,
  input  wire logic [PortPayW-1:0] new_payload_i,
  input  wire logic [RankW-1:0]    rank_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               status_o,
  output logic [KeyW-1:0]          out_key_o,
  output logic [PortPayW-1:0]      out_payload_o,
  output logic [OccW-1:0]          occupancy_o
);

  spq_state_e state_q, state_d;

  logic [1:0]      cmd_q;
  logic [KeyW-1:0] key_q;
  logic [PayW-1:0] pay_q;
  logic [RankW-1:0] rank_q;
  logic [CntW-1:0] count_q, count_d;

  logic            out_valid_q, out_valid_d;
  logic [1:0]      status_q, status_d;
  logic [KeyW-1:0] okey_q, okey_d;
  logic [PayW-1:0] opay_q, opay_d;
  logic [OccW-1:0] occ_q;

  logic            in_accept;
  logic            out_free;
  logic            load_out;
  logic            full;
  logic            empty;
  logic            rank_bad;
  spq_cell_ctrl_t  ctrl;

  logic [KeyW-1:0] cell_key [DEPTH];
  logic [PayW-1:0] cell_pay [DEPTH];
  logic [KeyW-1:0] sel_key  [DEPTH];
  logic [PayW-1:0] sel_pay  [DEPTH];
  logic            cell_ge  [DEPTH];
  logic [KeyW-1:0] tree_key;
  logic [PayW-1:0] tree_pay;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);
  assign rank_bad   = (RankCmpW'(rank_q) >= RankCmpW'(count_q));

  // Command capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= command_i;
      key_q  <= new_key_i;
      pay_q  <= new_payload_i[PayW-1:0];
      rank_q <= rank_i;
    end
  end

  // Sequencer: next state, cell strobes and result word
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ctrl     = '0;
    load_out = 1'b0;
    status_d = STATUS_OK;
    okey_d   = '0;
    opay_d   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_q == CMD_READ) begin
          state_d = ST_RD1;
        end else if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
          case (cmd_q)
            CMD_INSERT: begin
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                ctrl.ins = 1'b1;
                count_d  = count_q + CntW'(1);
              end
            end
            CMD_REMOVE: begin
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                ctrl.rem = 1'b1;
                okey_d   = cell_key[0];
                opay_d   = cell_pay[0];
                count_d  = count_q - CntW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD1: begin
        state_d = ST_RD2;
      end
      ST_RD2: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
          if (rank_bad) begin
            status_d = STATUS_RANK;
          end else begin
            okey_d = tree_key;
            opay_d = tree_pay;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out)         out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q <= status_d;
      okey_q   <= okey_d;
      opay_q   <= opay_d;
      occ_q    <= OccW'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_key_o     = okey_q;
  assign out_payload_o = PortPayW'(opay_q);
  assign occupancy_o   = occ_q;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            prev_ge;
    logic [KeyW-1:0] prev_key, next_key;
    logic [PayW-1:0] prev_pay, next_pay;

    if (i == 0) begin : g_first
      assign prev_ge  = 1'b1;
      assign prev_key = key_q;
      assign prev_pay = pay_q;
    end else begin : g_mid
      assign prev_ge  = cell_ge[i-1];
      assign prev_key = cell_key[i-1];
      assign prev_pay = cell_pay[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign next_key = cell_key[i];
      assign next_pay = cell_pay[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
      assign next_pay = cell_pay[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (CntW'(i) < count_q),
      .hit_i      (RankCmpW'(rank_q) == RankCmpW'(i)),
      .new_key_i  (key_q),
      .new_pay_i  (pay_q),
      .prev_ge_i  (prev_ge),
      .prev_key_i (prev_key),
      .prev_pay_i (prev_pay),
      .next_key_i (next_key),
      .next_pay_i (next_pay),
      .ge_o       (cell_ge[i]),
      .key_o      (cell_key[i]),
      .pay_o      (cell_pay[i]),
      .sel_key_o  (sel_key[i]),
      .sel_pay_o  (sel_pay[i])
    );
  end

  // Rank read gather
  spq_rank_tree u_tree (
    .clk_i     (clk_i),
    .sel_key_i (sel_key),
    .sel_pay_i (sel_pay),
    .key_o     (tree_key),
    .pay_o     (tree_pay)
  );

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.ins) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow the count");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.rem) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("remove did not shrink the count");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (cell_key[0] >= cell_key[1]))
    else $error("head of chain out of order");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_accept)
    else $error("command accepted while busy");

endmodule

`default_nettype wire

>>> bench/spq_checker.sv
// Checker for the sorted priority queue: mirrors the queue contents and checks every result word.
`timescale 1ns / 1ps

module spq_checker
  import spq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_i,
  input  wire logic [1:0]          command_i,
  input  wire logic [KeyW-1:0]     new_key_i,
  input  wire logic [PortPayW-1:0] new_payload_i,
  input  wire logic [RankW-1:0]    rank_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_stall_i,
  input  wire logic [1:0]          status_i,
  input  wire logic [KeyW-1:0]     out_key_i,
  input  wire logic [PortPayW-1:0] out_payload_i,
  input  wire logic [OccW-1:0]     occupancy_i,
  output int unsigned              fail_count_o,
  output int unsigned              words_due_o
);

  localparam logic [PortPayW-1:0] PayMask = {PortPayW{1'b1}} >> (PortPayW - PayW);

  typedef struct packed {
    logic [1:0]          status;
    logic [KeyW-1:0]     key;
    logic [PortPayW-1:0] payload;
    logic [OccW-1:0]     occupancy;
  } queue_result_t;

  // Shadow copy of the queue, largest key first
  logic [KeyW-1:0]     shadow_keys [DEPTH];
  logic [PortPayW-1:0] shadow_pays [DEPTH];
  int                  shadow_count;

  queue_result_t due_results [$];
  int unsigned   fails;

  initial begin
    shadow_count = 0;
    fails        = 0;
    fail_count_o = 0;
    words_due_o  = 0;
  end

  // Apply one command to the shadow queue and return the result word it should give
  function automatic queue_result_t apply_command(logic [1:0] cmd, logic [KeyW-1:0] key,
                                                  logic [PortPayW-1:0] pay,
                                                  logic [RankW-1:0] rank);
    queue_result_t res;
    int            pos;
    int            i;
    res = '0;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_count >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          // first slot with a strictly smaller key, so ties keep arrival order
          pos = 0;
          while (pos < shadow_count && shadow_keys[pos] >= key) pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_pays[i] = shadow_pays[i-1];
          end
          shadow_keys[pos] = key;
          shadow_pays[pos] = pay & PayMask;
          shadow_count++;
          res.status = STATUS_OK;
        end
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.status  = STATUS_OK;
          res.key     = shadow_keys[0];
          res.payload = shadow_pays[0];
          for (i = 1; i < shadow_count; i++) begin
            shadow_keys[i-1] = shadow_keys[i];
            shadow_pays[i-1] = shadow_pays[i];
          end
          shadow_count--;
        end
      end
      CMD_READ: begin
        if (int'(rank) >= shadow_count || int'(rank) >= DEPTH) begin
          res.status = STATUS_RANK;
        end else begin
          res.status  = STATUS_OK;
          res.key     = shadow_keys[rank];
          res.payload = shadow_pays[rank];
        end
      end
      default: res.status = STATUS_OK;  // unused code leaves the queue alone
    endcase
    res.occupancy = OccW'(shadow_count);
    return res;
  endfunction

  // Result words are compared first: none can come from a command taken on the same edge
  always @(posedge clk_i) begin : watch
    queue_result_t got;
    queue_result_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        got.status    = status_i;
        got.key       = out_key_i;
        got.payload   = out_payload_i;
        got.occupancy = occupancy_i;
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result word with none due: st=%0d key=%h pay=%h occ=%0d",
                     $realtime, got.status, got.key, got.payload, got.occupancy);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch: want st=%0d key=%h pay=%h occ=%0d,",
                       $realtime, want.status, want.key, want.payload, want.occupancy,
                       " got st=%0d key=%h pay=%h occ=%0d",
                       got.status, got.key, got.payload, got.occupancy);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        due_results.push_back(apply_command(command_i, new_key_i, new_payload_i, rank_i));
      fail_count_o = fails;
      words_due_o  = due_results.size();
    end
  end

endmodule

>>> bench/tb_sorted_priority_queue.sv
// Testbench top for the sorted priority queue: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HoldAt     = 150;     // result count at which the receiver holds off
  localparam int HoldLen    = 300;
  localparam int CycleLimit = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          command;
  logic [KeyW-1:0]     new_key;
  logic [PortPayW-1:0] new_payload;
  logic [RankW-1:0]    rank;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          status;
  logic [KeyW-1:0]     out_key;
  logic [PortPayW-1:0] out_payload;
  logic [OccW-1:0]     occupancy;
  int unsigned         fail_count;
  int unsigned         words_due;

  bit          tx_idle;
  bit          rx_idle;
  int          held;      // entries the queue should hold, used only to steer stimulus
  int unsigned cycles;

  sorted_priority_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .command_i     (command),
    .new_key_i     (new_key),
    .new_payload_i (new_payload),
    .rank_i        (rank),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .out_key_o     (out_key),
    .out_payload_o (out_payload),
    .occupancy_o   (occupancy)
  );

  spq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .command_i     (command),
    .new_key_i     (new_key),
    .new_payload_i (new_payload),
    .rank_i        (rank),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .status_i      (status),
    .out_key_i     (out_key),
    .out_payload_i (out_payload),
    .occupancy_i   (occupancy),
    .fail_count_o  (fail_count),
    .words_due_o   (words_due)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** sorted_priority_queue: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall after each result word while idling is on, plus one long hold-off
  initial begin : receiver
    int  wait_left;
    int  taken;
    bit  took;
    wait_left = 0;
    taken     = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      took = (out_valid === 1'b1) && !out_stall;
      @(negedge clk_i);
      if (took) begin
        taken++;
        if (taken == HoldAt) wait_left = HoldLen;
        else wait_left = rx_idle ? $urandom_range(0, 15) : 0;
      end
      if (wait_left > 0) begin
        out_stall = 1'b1;
        wait_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Offer one command word, after a random gap while idling is on, and hold it until taken
  task automatic send_word(input logic [1:0] cmd, input logic [KeyW-1:0] key,
                           input logic [PortPayW-1:0] pay, input logic [RankW-1:0] rk);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid    = 1'b1;
    command     = cmd;
    new_key     = key;
    new_payload = pay;
    rank        = rk;
    do @(posedge clk_i); while (in_stall);
    if (cmd == CMD_INSERT && held < DEPTH) held++;
    if (cmd == CMD_REMOVE && held > 0) held--;
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? '1 : '0;
      1:       return KeyW'($urandom_range(0, 7));   // narrow range to force ties
      default: return KeyW'($urandom());
    endcase
  endfunction

  function automatic logic [RankW-1:0] pick_rank();
    if (held > 0 && $urandom_range(0, 3) != 0)
      return RankW'($urandom_range(0, held - 1));
    return RankW'($urandom_range(0, 255));
  endfunction

  // One random command word; weights in percent, the rest goes to the unused code
  task automatic send_random(input int ins_w, input int rem_w, input int rd_w);
    int         roll;
    logic [1:0] cmd;
    roll = $urandom_range(0, 99);
    if (roll < ins_w) cmd = CMD_INSERT;
    else if (roll < ins_w + rem_w) cmd = CMD_REMOVE;
    else if (roll < ins_w + rem_w + rd_w) cmd = CMD_READ;
    else cmd = CMD_UNUSED;
    send_word(cmd, pick_key(), $urandom(), pick_rank());
  endtask

  initial begin : stimulus
    int i;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    command     = CMD_INSERT;
    new_key     = '0;
    new_payload = '0;
    rank        = '0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    held        = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty queue, extremes, ties, rank limits, unused code
    send_word(CMD_REMOVE, '0, '0, '0);
    send_word(CMD_READ, '0, '0, '0);
    send_word(CMD_UNUSED, '1, '1, '1);
    send_word(CMD_INSERT, '0, '0, '1);
    send_word(CMD_INSERT, '1, '1, '0);
    send_word(CMD_INSERT, 16'h8000, 32'h1111_1111, '0);
    send_word(CMD_INSERT, 16'h8000, 32'h2222_2222, '0);
    send_word(CMD_INSERT, 16'h0001, 32'h8000_0001, '0);
    for (i = 0; i < 6; i++) send_word(CMD_READ, KeyW'($urandom()), $urandom(), RankW'(i));
    send_word(CMD_READ, '0, '0, '1);
    send_word(CMD_UNUSED, KeyW'($urandom()), $urandom(), RankW'($urandom()));
    for (i = 0; i < 6; i++)
      send_word(CMD_REMOVE, KeyW'($urandom()), $urandom(), RankW'($urandom()));

    // Random mix with idling on both sides
    repeat (40) send_random(45, 30, 20);

    // Fill to capacity with no idling; the long receiver hold-off lands here
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    while (held < DEPTH) send_random(95, 1, 4);
    send_word(CMD_INSERT, '1, '1, '0);
    send_word(CMD_INSERT, '0, '0, '0);
    repeat (4) send_random(100, 0, 0);
    send_word(CMD_READ, '0, '0, '1);
    send_word(CMD_READ, '0, '0, '0);
    repeat (4) send_random(0, 0, 100);

    // Drain past empty with idling back on
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    while (held > 0) send_random(1, 95, 4);
    send_word(CMD_REMOVE, KeyW'($urandom()), $urandom(), RankW'($urandom()));
    send_word(CMD_READ, KeyW'($urandom()), $urandom(), '0);

    repeat (20) send_random(40, 30, 25);

    @(negedge clk_i);
    in_valid = 1'b0;
    while (words_due != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0)
      $display("** sorted_priority_queue: PASSED **");
    else
      $display("** sorted_priority_queue: FAILED **");
    $finish;
  end

endmodule
